// ===== design/gtlt_pkg.sv =====
// Shared types and constants for the GNSS takeoff latch timer.
// No dependencies; gtlt_detect and the top level refer to it by scoped names.
`default_nettype none

package gtlt_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIMB_RATE    = 2'd0,
        REG_CLIMB_HOLD    = 2'd1,
        REG_FREEFALL_RATE = 2'd2,
        REG_FREEFALL_HOLD = 2'd3
    } cfg_idx_t;

    localparam logic [7:0]  USABLE_FIX = 8'd3;
    localparam logic [31:0] WEEK_MS    = 32'd604800000;

    localparam logic [15:0] CLIMB_RATE_RST    = 16'd2500;
    localparam logic [19:0] CLIMB_HOLD_RST    = 20'd8000;
    localparam logic [15:0] FREEFALL_RATE_RST = 16'd10000;
    localparam logic [19:0] FREEFALL_HOLD_RST = 20'd1000;

    // floor(x / 1000) == (x * RECIP_1000) >> DIV_SHIFT for every 32-bit x.
    localparam int RECIP_W = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
    localparam int DIV_SHIFT = 38;
    localparam int PROD_W = 32 + RECIP_W;
    localparam int SECS_W = 23;

    typedef struct packed {
        logic [15:0] climb_rate;
        logic [19:0] climb_hold;
        logic [15:0] fall_rate;
        logic [19:0] fall_hold;
    } cfg_t;

    typedef struct packed {
        logic        tk_edge;
        logic        flight;
        logic [31:0] ms;
    } stage_t;

endpackage

`default_nettype wire

// ===== design/gtlt_if.sv =====
// Stream interfaces for GNSS samples and timer results.
// Depends on nothing; used by the top level.
`default_nettype none

interface gtlt_sample_if;
    logic               valid;
    logic               ready;
    logic               sample_present;
    logic [7:0]         fix_type;
    logic signed [31:0] vel_down_mm_s;
    logic [31:0]        time_of_week_ms;

    modport source (output valid, sample_present, fix_type, vel_down_mm_s,
                    time_of_week_ms, input ready);
    modport sink   (input valid, sample_present, fix_type, vel_down_mm_s,
                    time_of_week_ms, output ready);
endinterface

interface gtlt_result_if;
    logic        valid;
    logic        ready;
    logic        takeoff_edge;
    logic        in_flight;
    logic        elapsed_valid;
    logic [22:0] elapsed_seconds;

    modport source (output valid, takeoff_edge, in_flight, elapsed_valid,
                    elapsed_seconds, input ready);
    modport sink   (input valid, takeoff_edge, in_flight, elapsed_valid,
                    elapsed_seconds, output ready);
endinterface

`default_nettype wire

// ===== design/gtlt_detect.sv =====
// Takeoff detector: the two sustain windows, the flight latch and the time stamps.
// Depends on gtlt_pkg. Updates its state on every accepted sample beat.
`default_nettype none

module gtlt_detect (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire gtlt_pkg::cfg_t     cfg,
    input  wire logic               present,
    input  wire logic [7:0]         fix,
    input  wire logic signed [31:0] vel,
    input  wire logic [31:0]        tow,
    output gtlt_pkg::stage_t        res
);

    logic        flight_reg, flight_next;
    logic        climb_open_reg, climb_open_next;
    logic [31:0] climb_start_reg, climb_start_next;
    logic        fall_open_reg, fall_open_next;
    logic [31:0] fall_start_reg, fall_start_next;
    logic [31:0] takeoff_reg, takeoff_next;
    logic [31:0] newest_reg, newest_next;

    logic [32:0] vel_ext;
    logic [32:0] climb_lim;
    logic        climb_cond;
    logic        fall_cond;
    logic        climb_due;
    logic        fall_due;
    logic        latch;

    assign vel_ext    = {vel[31], vel};
    assign climb_lim  = 33'd0 - {17'd0, cfg.climb_rate};
    assign climb_cond = $signed(vel_ext) <= $signed(climb_lim);
    assign fall_cond  = $signed(vel_ext) >= $signed({17'd0, cfg.fall_rate});
    assign climb_due  = (tow - climb_start_reg) >= {12'd0, cfg.climb_hold};
    assign fall_due   = (tow - fall_start_reg) >= {12'd0, cfg.fall_hold};

    always_comb
    begin
        flight_next      = flight_reg;
        climb_open_next  = climb_open_reg;
        climb_start_next = climb_start_reg;
        fall_open_next   = fall_open_reg;
        fall_start_next  = fall_start_reg;
        takeoff_next     = takeoff_reg;
        newest_next      = newest_reg;
        latch            = 1'b0;

        if (flight_reg)
        begin
            if (present)
            begin
                newest_next = tow;
            end
        end
        else if (!present || fix != gtlt_pkg::USABLE_FIX)
        begin
            climb_open_next = 1'b0;
            fall_open_next  = 1'b0;
        end
        else
        begin
            // The climb is judged first; a climb latch leaves the fall window as it was.
            if (climb_cond)
            begin
                if (!climb_open_reg)
                begin
                    climb_open_next  = 1'b1;
                    climb_start_next = tow;
                end
                else if (climb_due)
                begin
                    latch = 1'b1;
                end
            end
            else
            begin
                climb_open_next = 1'b0;
            end

            if (!latch)
            begin
                if (fall_cond)
                begin
                    if (!fall_open_reg)
                    begin
                        fall_open_next  = 1'b1;
                        fall_start_next = tow;
                    end
                    else if (fall_due)
                    begin
                        latch = 1'b1;
                    end
                end
                else
                begin
                    fall_open_next = 1'b0;
                end
            end
        end

        if (latch)
        begin
            flight_next  = 1'b1;
            takeoff_next = tow;
            newest_next  = tow;
        end
    end

    assign res.tk_edge = latch;
    assign res.flight  = flight_next;
    assign res.ms      = flight_next ? (newest_next - takeoff_next) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg      <= 1'b0;
            climb_open_reg  <= 1'b0;
            climb_start_reg <= 32'd0;
            fall_open_reg   <= 1'b0;
            fall_start_reg  <= 32'd0;
            takeoff_reg     <= 32'd0;
            newest_reg      <= 32'd0;
        end
        else if (en)
        begin
            flight_reg      <= flight_next;
            climb_open_reg  <= climb_open_next;
            climb_start_reg <= climb_start_next;
            fall_open_reg   <= fall_open_next;
            fall_start_reg  <= fall_start_next;
            takeoff_reg     <= takeoff_next;
            newest_reg      <= newest_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/gnss_takeoff_latch_timer.sv =====
// Top level of the GNSS takeoff latch timer: configuration registers, detector
// and a three-stage result pipeline. Depends on gtlt_pkg, gtlt_if and gtlt_detect.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------------
//   sample   | in  | valid/ready      | sample_present, fix_type, vel_down_mm_s,
//            |     |                  | time_of_week_ms
//   result   | out | valid/ready      | takeoff_edge, in_flight, elapsed_valid,
//            |     |                  | elapsed_seconds
//   cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// One sample beat is taken per cycle unless a result beat stalls; its result moves
// through s1, then s2 (week correction), then stage 3 (reciprocal multiply, /1000).
// The detector state updates on the accepting edge, so back-to-back beats see it.
// A stalled result beat holds the whole pipeline and drops sample.ready.
// Reset clears the detector state and loads the default register values.
`default_nettype none

module gnss_takeoff_latch_timer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    gtlt_sample_if.sink                             sample,
    gtlt_result_if.source                           result,
    input  wire logic                               cfg_we,
    input  wire logic [gtlt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gtlt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gtlt_pkg::cfg_t   cfg_reg;
    gtlt_pkg::stage_t det_res;
    gtlt_pkg::stage_t s1_reg;
    gtlt_pkg::stage_t s2_reg;
    gtlt_pkg::stage_t s2_next;

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        edge3_reg, flight3_reg;
    logic [gtlt_pkg::PROD_W-1:0] prod_reg;
    logic                        advance;
    logic                        accept;

    assign advance      = !v3_reg || result.ready;
    assign sample.ready = advance;
    assign accept       = sample.valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.climb_rate <= gtlt_pkg::CLIMB_RATE_RST;
            cfg_reg.climb_hold <= gtlt_pkg::CLIMB_HOLD_RST;
            cfg_reg.fall_rate  <= gtlt_pkg::FREEFALL_RATE_RST;
            cfg_reg.fall_hold  <= gtlt_pkg::FREEFALL_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (gtlt_pkg::cfg_idx_t'(cfg_index))
                gtlt_pkg::REG_CLIMB_RATE:    cfg_reg.climb_rate <= cfg_data[15:0];
                gtlt_pkg::REG_CLIMB_HOLD:    cfg_reg.climb_hold <= cfg_data;
                gtlt_pkg::REG_FREEFALL_RATE: cfg_reg.fall_rate  <= cfg_data[15:0];
                gtlt_pkg::REG_FREEFALL_HOLD: cfg_reg.fall_hold  <= cfg_data;
                default: ;
            endcase
        end
    end

    gtlt_detect u_detect (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .cfg     (cfg_reg),
        .present (sample.sample_present),
        .fix     (sample.fix_type),
        .vel     (sample.vel_down_mm_s),
        .tow     (sample.time_of_week_ms),
        .res     (det_res)
    );

    // A gap of at least one week is pushed forward by another week, modulo 2^32.
    always_comb
    begin
        s2_next = s1_reg;
        if (s1_reg.ms >= gtlt_pkg::WEEK_MS)
        begin
            s2_next.ms = s1_reg.ms + gtlt_pkg::WEEK_MS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg      <= det_res;
            s2_reg      <= s2_next;
            edge3_reg   <= s2_reg.tk_edge;
            flight3_reg <= s2_reg.flight;
            prod_reg    <= {29'd0, s2_reg.ms} * {32'd0, gtlt_pkg::RECIP_1000};
        end
    end

    assign result.valid           = v3_reg;
    assign result.takeoff_edge    = edge3_reg;
    assign result.in_flight       = flight3_reg;
    assign result.elapsed_valid   = flight3_reg;
    assign result.elapsed_seconds =
        prod_reg[gtlt_pkg::DIV_SHIFT +: gtlt_pkg::SECS_W];

endmodule

`default_nettype wire

// ===== design/gtlt_checker.sv =====
// Port-level checker for the GNSS takeoff latch timer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module gtlt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        takeoff_edge,
    input wire logic        in_flight,
    input wire logic        elapsed_valid,
    input wire logic [22:0] elapsed_seconds
);

    logic seen_flight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_flight_reg <= 1'b0;
        end
        else if (out_valid && out_ready && in_flight)
        begin
            seen_flight_reg <= 1'b1;
        end
    end

    // Once a beat has shown flight, the latch never drops and never fires again.
    a_latch_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_flight_reg) |-> (in_flight && !takeoff_edge))
        else $error("flight latch dropped or fired twice");

    a_edge_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && takeoff_edge) |-> (in_flight && elapsed_seconds == 23'd0))
        else $error("takeoff beat without flight or with nonzero time");

    a_ground_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_flight) |-> (!elapsed_valid && elapsed_seconds == 23'd0))
        else $error("elapsed time reported on the ground");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elapsed_valid == in_flight))
        else $error("elapsed_valid differs from in_flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(elapsed_seconds)))
        else $error("stalled result beat changed");

endmodule

bind gnss_takeoff_latch_timer gtlt_checker u_gtlt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .takeoff_edge    (result.takeoff_edge),
    .in_flight       (result.in_flight),
    .elapsed_valid   (result.elapsed_valid),
    .elapsed_seconds (result.elapsed_seconds)
);

`default_nettype wire

// ===== test/tb_gnss_takeoff_latch_timer.sv =====
// Self-checking testbench for gnss_takeoff_latch_timer: drives GNSS sample beats,
// predicts every result beat and compares it field by field.
// Depends on gtlt_pkg, gtlt_if and the design top level.
`default_nettype none

module tb_gnss_takeoff_latch_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LATENCY     = 3;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam longint VEL_MIN     = -64'sd2147483648;
    localparam longint VEL_MAX     = 64'sd2147483647;

    typedef struct {
        bit               present;
        bit [7:0]         fix;
        bit signed [31:0] vdown;
        bit [31:0]        tow;
    } gnss_sample_t;

    typedef struct {
        bit        takeoff;
        bit        flight;
        bit        secs_valid;
        bit [22:0] secs;
    } timer_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [gtlt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gtlt_pkg::CFG_DATA_W-1:0] cfg_data;

    gtlt_sample_if sample_ch ();
    gtlt_result_if result_ch ();

    gnss_takeoff_latch_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Predicted register copies and detector state.
    bit [15:0] r_climb_rate;
    bit [19:0] r_climb_hold;
    bit [15:0] r_fall_rate;
    bit [19:0] r_fall_hold;
    bit        latched;
    bit        climb_open;
    bit [31:0] climb_start;
    bit        fall_open;
    bit [31:0] fall_start;
    bit [31:0] t_takeoff;
    bit [31:0] t_newest;

    timer_report_t pending_reports[$];
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_off_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_stall_on = 1'b1;

    task automatic reset_model();
        r_climb_rate = gtlt_pkg::CLIMB_RATE_RST;
        r_climb_hold = gtlt_pkg::CLIMB_HOLD_RST;
        r_fall_rate  = gtlt_pkg::FREEFALL_RATE_RST;
        r_fall_hold  = gtlt_pkg::FREEFALL_HOLD_RST;
        latched      = 1'b0;
        climb_open   = 1'b0;
        climb_start  = '0;
        fall_open    = 1'b0;
        fall_start   = '0;
        t_takeoff    = '0;
        t_newest     = '0;
    endtask

    // Works out the report for one sample; the state moves on only when commit is set.
    function automatic timer_report_t advance_latch(gnss_sample_t s, bit commit);
        bit            lat;
        bit            c_open;
        bit            f_open;
        bit            hit;
        bit [31:0]     c_start;
        bit [31:0]     f_start;
        bit [31:0]     t_off;
        bit [31:0]     t_new;
        bit [31:0]     dt;
        bit [31:0]     ms;
        timer_report_t rep;
        lat     = latched;
        c_open  = climb_open;
        f_open  = fall_open;
        c_start = climb_start;
        f_start = fall_start;
        t_off   = t_takeoff;
        t_new   = t_newest;
        hit     = 1'b0;
        if (lat)
        begin
            if (s.present)
                t_new = s.tow;
        end
        else if (!s.present || s.fix != gtlt_pkg::USABLE_FIX)
        begin
            c_open = 1'b0;
            f_open = 1'b0;
        end
        else
        begin
            if (longint'(s.vdown) <= -longint'(r_climb_rate))
            begin
                if (!c_open)
                begin
                    c_open  = 1'b1;
                    c_start = s.tow;
                end
                else
                begin
                    dt = s.tow - c_start;
                    if (dt >= {12'd0, r_climb_hold})
                        hit = 1'b1;
                end
            end
            else
            begin
                c_open = 1'b0;
            end
            // A climb latch leaves the fall window untouched.
            if (!hit)
            begin
                if (longint'(s.vdown) >= longint'(r_fall_rate))
                begin
                    if (!f_open)
                    begin
                        f_open  = 1'b1;
                        f_start = s.tow;
                    end
                    else
                    begin
                        dt = s.tow - f_start;
                        if (dt >= {12'd0, r_fall_hold})
                            hit = 1'b1;
                    end
                end
                else
                begin
                    f_open = 1'b0;
                end
            end
            if (hit)
            begin
                lat   = 1'b1;
                t_off = s.tow;
                t_new = s.tow;
            end
        end
        ms = t_new - t_off;
        if (ms >= gtlt_pkg::WEEK_MS)
            ms = ms + gtlt_pkg::WEEK_MS;
        ms = ms / 32'd1000;
        rep.takeoff    = hit;
        rep.flight     = lat;
        rep.secs_valid = lat;
        rep.secs       = lat ? ms[22:0] : '0;
        if (commit)
        begin
            latched     = lat;
            climb_open  = c_open;
            fall_open   = f_open;
            climb_start = c_start;
            fall_start  = f_start;
            t_takeoff   = t_off;
            t_newest    = t_new;
        end
        return rep;
    endfunction

    function automatic gnss_sample_t mk(bit p, bit [7:0] f, bit signed [31:0] v,
                                        bit [31:0] t);
        gnss_sample_t s;
        s.present = p;
        s.fix     = f;
        s.vdown   = v;
        s.tow     = t;
        return s;
    endfunction

    function automatic int idle_gap();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(gnss_sample_t s);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.sample_present  <= s.present;
        sample_ch.fix_type        <= s.fix;
        sample_ch.vel_down_mm_s   <= s.vdown;
        sample_ch.time_of_week_ms <= s.tow;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_reports.push_back(advance_latch(s, 1'b1));
    endtask

    // Before takeoff is wanted, a beat that would latch is turned into a window break.
    task automatic send_ground(gnss_sample_t s);
        timer_report_t probe;
        probe = advance_latch(s, 1'b0);
        if (probe.takeoff)
        begin
            s.present = 1'($urandom_range(0, 1));
            s.fix     = 8'(gtlt_pkg::USABLE_FIX + $urandom_range(1, 255));
        end
        send_sample(s);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(gtlt_pkg::cfg_idx_t idx, bit [19:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            gtlt_pkg::REG_CLIMB_RATE:    r_climb_rate = data[15:0];
            gtlt_pkg::REG_CLIMB_HOLD:    r_climb_hold = data;
            gtlt_pkg::REG_FREEFALL_RATE: r_fall_rate  = data[15:0];
            gtlt_pkg::REG_FREEFALL_HOLD: r_fall_hold  = data;
            default: ;
        endcase
    endtask

    // Upper data bits of the rate registers carry junk to check the width mask.
    task automatic set_config(bit [15:0] climb_rate, bit [19:0] climb_hold,
                              bit [15:0] fall_rate, bit [19:0] fall_hold);
        bit [19:0] junk;
        junk = 20'($urandom);
        write_reg(gtlt_pkg::REG_CLIMB_RATE, {junk[19:16], climb_rate});
        write_reg(gtlt_pkg::REG_CLIMB_HOLD, climb_hold);
        write_reg(gtlt_pkg::REG_FREEFALL_RATE, {junk[3:0], fall_rate});
        write_reg(gtlt_pkg::REG_FREEFALL_HOLD, fall_hold);
        cfg_we <= 1'b0;
    endtask

    function automatic bit signed [31:0] climb_speed();
        longint v;
        int     r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = -longint'(r_climb_rate);
        else if (r == 1)
            v = VEL_MIN;
        else
            v = -longint'(r_climb_rate) - longint'($urandom_range(0, 100000));
        if (v < VEL_MIN)
            v = VEL_MIN;
        return v[31:0];
    endfunction

    function automatic bit signed [31:0] fall_speed();
        longint v;
        int     r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = longint'(r_fall_rate);
        else if (r == 1)
            v = VEL_MAX;
        else
            v = longint'(r_fall_rate) + longint'($urandom_range(0, 100000));
        if (v > VEL_MAX)
            v = VEL_MAX;
        return v[31:0];
    endfunction

    function automatic gnss_sample_t noise_sample();
        gnss_sample_t s;
        s.present = $urandom_range(0, 3) != 0;
        s.fix     = $urandom_range(0, 1) ? gtlt_pkg::USABLE_FIX : 8'($urandom_range(0, 255));
        s.vdown   = $urandom;
        s.tow     = $urandom;
        return s;
    endfunction

    // Time offset inside a window; a last beat that is not the first sits one ms short of a nonzero hold.
    function automatic bit [31:0] window_offset(bit [19:0] hold, int i, int last);
        if (i == 0 || hold == 20'd0)
            return 0;
        if (i == last)
            return {12'd0, hold} - 32'd1;
        if ($urandom_range(0, 9) == 0)
            return {12'd0, hold} + $urandom_range(0, 100);
        return $urandom_range(0, {12'd0, hold} - 32'd1);
    endfunction

    task automatic run_windows(int n_items);
        int           sent;
        int           run_len;
        int           kind;
        bit [31:0]    start;
        bit [19:0]    hold;
        gnss_sample_t s;
        sent = 0;
        while (sent < n_items)
        begin
            kind    = $urandom_range(0, 99);
            run_len = $urandom_range(1, 10);
            if ($urandom_range(0, 4) == 0)
                start = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            else
                start = $urandom;
            hold = (kind < 55) ? r_climb_hold : r_fall_hold;
            for (int i = 0; i < run_len; i++)
            begin
                if (kind < 88)
                begin
                    s.present = 1'b1;
                    s.fix     = gtlt_pkg::USABLE_FIX;
                    s.vdown   = (kind < 55) ? climb_speed() : fall_speed();
                    s.tow     = start + window_offset(hold, i, run_len - 1);
                end
                else
                begin
                    s = noise_sample();
                end
                send_ground(s);
                sent++;
            end
            s = noise_sample();
            case ($urandom_range(0, 3))
                0: s.present = 1'b0;
                1:
                begin
                    s.present = 1'b1;
                    s.fix     = 8'(gtlt_pkg::USABLE_FIX + $urandom_range(1, 255));
                end
                2:
                begin
                    s.present = 1'b1;
                    s.fix     = gtlt_pkg::USABLE_FIX;
                    s.vdown   = 1 - int'(r_climb_rate);
                end
                default:
                begin
                    s.present = 1'b1;
                    s.fix     = gtlt_pkg::USABLE_FIX;
                    s.vdown   = int'(r_fall_rate) - 1;
                end
            endcase
            s.tow = start + $urandom_range(0, 1000);
            send_ground(s);
            sent++;
        end
    endtask

    task automatic test_ground_cases();
        gnss_sample_t dir[$];
        dir.push_back(mk(1'b0, 8'hFF, 32'shFFFF_FFFF, 32'hFFFF_FFFF));
        dir.push_back(mk(1'b1, 8'h00, 32'sh8000_0000, 32'h0000_0000));
        dir.push_back(mk(1'b1, 8'd2, -5000, 100));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, -2500, 1000));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, -3000, 8999));
        dir.push_back(mk(1'b1, 8'd4, -3000, 9000));
        // Reopened window: the opening beat is never judged against the hold.
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, -2500, 9001));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, -2499, 20000));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, 32'sh7FFF_FFFF, 32'hFFFF_FE00));
        // Fall window across the 32-bit wrap, one ms short of the hold.
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, 10000, 32'h0000_01E7));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, 9999, 600));
        dir.push_back(mk(1'b0, 8'h00, 0, 0));
        dir.push_back(mk(1'b1, gtlt_pkg::USABLE_FIX, 0, 5));
        dir.push_back(mk(1'b1, 8'hFF, 10000, 6));
        foreach (dir[i])
            send_ground(dir[i]);
    endtask

    task automatic test_config_sweep();
        bit [15:0] cr;
        bit [15:0] fr;
        bit [19:0] ch;
        bit [19:0] fh;
        for (int k = 0; k < 10; k++)
        begin
            case (k)
                0:
                begin
                    cr = 16'h0000;
                    ch = 20'h00000;
                    fr = 16'h0000;
                    fh = 20'h00000;
                end
                1:
                begin
                    cr = 16'hFFFF;
                    ch = 20'hFFFFF;
                    fr = 16'hFFFF;
                    fh = 20'hFFFFF;
                end
                2:
                begin
                    cr = 16'h0000;
                    ch = 20'hFFFFF;
                    fr = 16'h0000;
                    fh = 20'hFFFFF;
                end
                3:
                begin
                    cr = 16'hFFFF;
                    ch = 20'h00000;
                    fr = 16'hFFFF;
                    fh = 20'h00000;
                end
                default:
                begin
                    cr = 16'($urandom_range(0, 65535));
                    fr = 16'($urandom_range(0, 65535));
                    ch = $urandom_range(0, 1) ? 20'($urandom_range(1, 5000))
                                              : 20'($urandom_range(0, 1048575));
                    fh = $urandom_range(0, 1) ? 20'($urandom_range(1, 5000))
                                              : 20'($urandom_range(0, 1048575));
                end
            endcase
            tx_idle_on  = (k % 3) != 0;
            rx_stall_on = (k % 3) != 0;
            drain();
            set_config(cr, ch, fr, fh);
            run_windows(155);
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Opens one window and takes it exactly to its hold, so the latch edge is checked.
    task automatic test_takeoff();
        bit        use_fall;
        bit [19:0] hold;
        bit [31:0] t0;
        gnss_sample_t s;
        use_fall = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0: hold = 20'h00000;
            1: hold = 20'hFFFFF;
            default: hold = 20'($urandom_range(1, 20000));
        endcase
        drain();
        set_config(16'($urandom_range(0, 65535)), hold, 16'($urandom_range(0, 65535)), hold);
        t0 = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2 * hold) : $urandom;
        send_sample(mk(1'b0, 8'h00, 0, t0));
        s.present = 1'b1;
        s.fix     = gtlt_pkg::USABLE_FIX;
        s.vdown   = use_fall ? fall_speed() : climb_speed();
        s.tow     = t0;
        send_sample(s);
        if (hold != 20'd0)
        begin
            s.vdown = use_fall ? fall_speed() : climb_speed();
            s.tow   = t0 + {12'd0, hold} - 32'd1;
            send_sample(s);
        end
        s.vdown = use_fall ? fall_speed() : climb_speed();
        s.tow   = t0 + {12'd0, hold};
        send_sample(s);
    endtask

    function automatic bit [31:0] flight_tow();
        case ($urandom_range(0, 7))
            0, 1, 2: return t_takeoff + $urandom_range(0, 3600000);
            3:       return t_takeoff + gtlt_pkg::WEEK_MS - 1 + $urandom_range(0, 2);
            4:       return t_takeoff + gtlt_pkg::WEEK_MS + $urandom_range(0, 100000);
            5:       return t_takeoff - $urandom_range(1, 5000);
            6:       return t_takeoff + 32'hFFFF_FFFF - $urandom_range(0, 2000);
            default: return $urandom;
        endcase
    endfunction

    task automatic flight_beats(int n_items);
        gnss_sample_t s;
        for (int i = 0; i < n_items; i++)
        begin
            s         = noise_sample();
            s.present = $urandom_range(0, 99) < 85;
            s.tow     = flight_tow();
            send_sample(s);
        end
    endtask

    task automatic test_flight_time();
        for (int k = 0; k < 3; k++)
        begin
            drain();
            if (k == 0)
                set_config(16'h0000, 20'h00000, 16'h0000, 20'h00000);
            else
                set_config(16'($urandom), 20'($urandom), 16'($urandom), 20'($urandom));
            flight_beats(100);
        end
    endtask

    // The receiver stops for a long stretch while beats keep coming back to back.
    task automatic test_backpressure();
        tx_idle_on      = 1'b0;
        hold_off_cycles = 200;
        flight_beats(40);
        tx_idle_on = 1'b1;
    endtask

    initial
    begin : rx_side
        int stall_left;
        int r;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else if (stall_left == 0 && rx_stall_on)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 23)
                    stall_left = $urandom_range(8, 40);
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : report_check
        timer_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result beat expected none, actual edge %0d flight %0d secs %0d",
                             $time, result_ch.takeoff_edge, result_ch.in_flight,
                             result_ch.elapsed_seconds);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("takeoff_edge", 32'(want.takeoff), 32'(result_ch.takeoff_edge));
                check_field("in_flight", 32'(want.flight), 32'(result_ch.in_flight));
                check_field("elapsed_valid", 32'(want.secs_valid),
                            32'(result_ch.elapsed_valid));
                check_field("elapsed_seconds", 32'(want.secs),
                            32'(result_ch.elapsed_seconds));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= '0;
        cfg_data                  <= '0;
        sample_ch.valid           <= 1'b0;
        sample_ch.sample_present  <= 1'b0;
        sample_ch.fix_type        <= '0;
        sample_ch.vel_down_mm_s   <= '0;
        sample_ch.time_of_week_ms <= '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ground_cases();
        test_config_sweep();
        test_takeoff();
        test_flight_time();
        test_backpressure();
        drain();
        if (pending_reports.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/gtlt_pkg.sv
design/gtlt_if.sv
design/gtlt_detect.sv
design/gnss_takeoff_latch_timer.sv
design/gtlt_checker.sv
test/tb_gnss_takeoff_latch_timer.sv
